@@ sv/aitp_pkg.sv @@
// Package for the archive index tree parser: phase and record codes, widths,
// result word type and small constant tables. No dependencies.
`default_nettype none
package aitp_pkg;
	localparam int MAX_DEPTH = 16;
	localparam int LVL_W = $clog2(MAX_DEPTH + 1);
	localparam int ADDR_W = $clog2(MAX_DEPTH);
	localparam int CNT_W = 32;
	localparam logic [7:0] LONG_NAME_MARK = 8'hFF;
	localparam logic [15:0] STAMP_LEN = 16'd64;
	localparam logic [7:0] KIND_DIR = 8'd1;
	localparam logic [7:0] VERSION_STAMPED = 8'd1;

	typedef enum logic [4:0] {
		PH_MAGIC, PH_VERSION, PH_HSIZE, PH_DSIZE, PH_STAMP, PH_NLEN, PH_NLEN_LO,
		PH_NLEN_HI, PH_NAME, PH_KIND, PH_COUNT, PH_OFFSET, PH_FLEN, PH_CSUM,
		PH_MARKER
	} phase_t;

	typedef enum logic [1:0] {C_IDLE, C_POP_RD, C_POP_WR} ctl_t;

	typedef enum logic [2:0] {
		REC_NAME = 3'd0, REC_DIR = 3'd1, REC_FILE = 3'd2, REC_HEADER = 3'd3,
		REC_MARKER = 3'd4, REC_ERROR = 3'd5
	} rec_kind_t;

	typedef enum logic [1:0] {
		ERR_MAGIC = 2'd0, ERR_TRUNC = 2'd1, ERR_NO_MARKER = 2'd2, ERR_DEEP = 2'd3
	} err_t;

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [4:0]  depth;
		logic [7:0]  name_char;
		logic [15:0] name_length;
		logic [31:0] child_count;
		logic [63:0] data_offset;
		logic [31:0] data_length;
		logic [31:0] file_checksum;
		logic [7:0]  format_version;
		logic [31:0] header_size;
		logic [31:0] payload_size;
		logic [1:0]  error_code;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] i);
		case (i)
			2'd0: magic_byte = 8'h50;
			2'd1: magic_byte = 8'h41;
			default: magic_byte = 8'h4B;
		endcase
	endfunction

	function automatic logic [7:0] marker_byte(input logic [1:0] i);
		case (i)
			2'd0: marker_byte = 8'h44;
			2'd1: marker_byte = 8'h41;
			2'd2: marker_byte = 8'h54;
			default: marker_byte = 8'h41;
		endcase
	endfunction
endpackage
`default_nettype wire

@@ sv/aitp_if.sv @@
// Handshake channels of the archive index tree parser: byte input and record
// output. No dependencies.
`default_nettype none
interface aitp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface aitp_rec_if;
	logic        valid;
	logic        ready;
	logic [2:0]  record_kind;
	logic [4:0]  depth;
	logic [7:0]  name_char;
	logic [15:0] name_length;
	logic [31:0] child_count;
	logic [63:0] data_offset;
	logic [31:0] data_length;
	logic [31:0] file_checksum;
	logic [7:0]  format_version;
	logic [31:0] header_size;
	logic [31:0] payload_size;
	logic [1:0]  error_code;
	modport source (output valid, record_kind, depth, name_char, name_length, child_count,
		data_offset, data_length, file_checksum, format_version, header_size,
		payload_size, error_code, input ready);
	modport sink (input valid, record_kind, depth, name_char, name_length, child_count,
		data_offset, data_length, file_checksum, format_version, header_size,
		payload_size, error_code, output ready);
endinterface
`default_nettype wire

@@ sv/archive_index_tree_parser.sv @@
// Archive index tree parser top level. Depends on aitp_pkg, aitp_if and aitp_ram.
//
// The parser takes one archive byte per accepted word. When a file entry or an
// empty directory completes, the open directory counts held in the child-count
// RAM are decremented one level at a time, each level with a read step and a
// write-back step; at most MAX_DEPTH levels are visited.
// A record is presented in an output register, and a new byte is taken while
// the previous record is being taken.
`default_nettype none
module archive_index_tree_parser (
	input wire logic clk,
	input wire logic arst_n,
	aitp_byte_if.sink arch,
	aitp_rec_if.source rec
);
	import aitp_pkg::*;

	phase_t phase_q, phase_n;
	ctl_t ctl_q, ctl_n;
	logic [15:0] cnt_q, cnt_n;
	logic [63:0] shift_q, shift_n;
	logic [15:0] nlen_q, nlen_n;
	logic [7:0] kind_q, kind_n;
	logic [63:0] off_q, off_n;
	logic [31:0] len_q, len_n;
	logic [LVL_W-1:0] lvl_q, lvl_n;
	logic fin_q, fin_n;
	logic last_q, last_n;
	res_t hold_q, hold_n;
	res_t out_q, out_n;
	logic out_valid_q, out_valid_n;

	logic acc, load;
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CNT_W-1:0] ram_wdata, ram_rdata;

	aitp_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DEPTH)) u_children (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign arch.ready = (ctl_q == C_IDLE) && (!out_valid_q || rec.ready);
	assign acc = arch.valid && arch.ready;

	always_comb begin
		logic [7:0] b;
		logic [15:0] cnt_inc;
		logic [63:0] tk;
		logic [3:0] need;
		logic done, have, err_v, fin_entry, rearm;
		logic [1:0] err_c;
		logic [31:0] dec;
		logic [LVL_W-1:0] lvl_d;
		res_t r;

		b = arch.data_byte;
		cnt_inc = cnt_q + 16'd1;
		tk = ((cnt_q == 16'd0) ? 64'd0 : shift_q) | (64'(b) << {cnt_q[2:0], 3'b000});
		need = 4'd4;
		have = 1'b0;
		err_v = 1'b0;
		err_c = ERR_MAGIC;
		fin_entry = 1'b0;
		rearm = 1'b0;
		r = '0;
		dec = ram_rdata - 32'd1;
		lvl_d = lvl_q - LVL_W'(1);

		phase_n = phase_q;
		ctl_n = ctl_q;
		cnt_n = cnt_q;
		shift_n = shift_q;
		nlen_n = nlen_q;
		kind_n = kind_q;
		off_n = off_q;
		len_n = len_q;
		lvl_n = lvl_q;
		fin_n = fin_q;
		last_n = last_q;
		hold_n = hold_q;
		ram_we = 1'b0;
		ram_waddr = lvl_q[ADDR_W-1:0];
		ram_wdata = '0;
		ram_raddr = lvl_d[ADDR_W-1:0];

		if (phase_q == PH_OFFSET && kind_q[1]) begin
			need = 4'd8;
		end
		done = (cnt_inc >= 16'(need));

		unique case (ctl_q)
			C_IDLE: begin
				if (acc && !fin_q) begin
					unique case (phase_q)
						PH_MAGIC: begin
							if (b != magic_byte(cnt_q[1:0])) begin
								err_v = 1'b1;
								err_c = ERR_MAGIC;
							end else if (cnt_inc >= 16'd3) begin
								cnt_n = '0;
								phase_n = PH_VERSION;
							end else begin
								cnt_n = cnt_inc;
							end
						end
						PH_VERSION: begin
							kind_n = b;
							cnt_n = '0;
							phase_n = PH_HSIZE;
						end
						PH_HSIZE: begin
							shift_n = tk;
							cnt_n = done ? 16'd0 : cnt_inc;
							if (done) begin
								len_n = tk[31:0];
								phase_n = PH_DSIZE;
							end
						end
						PH_DSIZE: begin
							shift_n = tk;
							cnt_n = done ? 16'd0 : cnt_inc;
							if (done) begin
								have = 1'b1;
								r.record_kind = REC_HEADER;
								r.format_version = kind_q;
								r.header_size = len_q;
								r.payload_size = tk[31:0];
								phase_n = (kind_q == VERSION_STAMPED) ? PH_STAMP : PH_NLEN;
							end
						end
						PH_STAMP: begin
							if (cnt_inc >= STAMP_LEN) begin
								cnt_n = '0;
								phase_n = PH_NLEN;
							end else begin
								cnt_n = cnt_inc;
							end
						end
						PH_NLEN: begin
							cnt_n = '0;
							if (b == LONG_NAME_MARK) begin
								phase_n = PH_NLEN_LO;
							end else begin
								nlen_n = 16'(b);
								phase_n = (b == 8'd0) ? PH_KIND : PH_NAME;
							end
						end
						PH_NLEN_LO: begin
							nlen_n = 16'(b);
							phase_n = PH_NLEN_HI;
						end
						PH_NLEN_HI: begin
							nlen_n = {b, nlen_q[7:0]};
							cnt_n = '0;
							phase_n = ({b, nlen_q[7:0]} == 16'd0) ? PH_KIND : PH_NAME;
						end
						PH_NAME: begin
							have = 1'b1;
							r.record_kind = REC_NAME;
							r.depth = 5'(lvl_q);
							r.name_char = b;
							r.name_length = nlen_q;
							if (cnt_inc >= nlen_q) begin
								cnt_n = '0;
								phase_n = PH_KIND;
							end else begin
								cnt_n = cnt_inc;
							end
						end
						PH_KIND: begin
							kind_n = b;
							cnt_n = '0;
							phase_n = (b == KIND_DIR) ? PH_COUNT : PH_OFFSET;
						end
						PH_COUNT: begin
							shift_n = tk;
							cnt_n = done ? 16'd0 : cnt_inc;
							if (done) begin
								if (tk[31:0] != 32'd0 && lvl_q >= LVL_W'(MAX_DEPTH)) begin
									err_v = 1'b1;
									err_c = ERR_DEEP;
								end else begin
									have = 1'b1;
									r.record_kind = REC_DIR;
									r.depth = 5'(lvl_q);
									r.name_length = nlen_q;
									r.child_count = tk[31:0];
									if (tk[31:0] == 32'd0) begin
										fin_entry = 1'b1;
									end else begin
										ram_we = 1'b1;
										ram_wdata = tk[31:0];
										lvl_n = lvl_q + LVL_W'(1);
										phase_n = PH_NLEN;
									end
								end
							end
						end
						PH_OFFSET: begin
							shift_n = tk;
							cnt_n = done ? 16'd0 : cnt_inc;
							if (done) begin
								off_n = tk;
								phase_n = PH_FLEN;
							end
						end
						PH_FLEN: begin
							shift_n = tk;
							cnt_n = done ? 16'd0 : cnt_inc;
							if (done) begin
								len_n = tk[31:0];
								phase_n = PH_CSUM;
							end
						end
						PH_CSUM: begin
							shift_n = tk;
							cnt_n = done ? 16'd0 : cnt_inc;
							if (done) begin
								have = 1'b1;
								r.record_kind = REC_FILE;
								r.depth = 5'(lvl_q);
								r.name_length = nlen_q;
								r.data_offset = off_q;
								r.data_length = len_q;
								r.file_checksum = tk[31:0];
								fin_entry = 1'b1;
							end
						end
						PH_MARKER: begin
							if (b != marker_byte(cnt_q[1:0])) begin
								err_v = 1'b1;
								err_c = ERR_NO_MARKER;
							end else if (cnt_inc >= 16'd4) begin
								cnt_n = '0;
								have = 1'b1;
								r.record_kind = REC_MARKER;
								fin_n = 1'b1;
							end else begin
								cnt_n = cnt_inc;
							end
						end
						default: begin
							fin_n = 1'b1;
						end
					endcase

					if (fin_entry && lvl_q != '0) begin
						// Hold the record until the pop walk through the open directory counts ends.
						have = 1'b0;
						hold_n = r;
						last_n = arch.last_byte;
						ctl_n = C_POP_RD;
					end else begin
						if (fin_entry) begin
							cnt_n = '0;
							phase_n = PH_MARKER;
						end
						if (!err_v && arch.last_byte && !fin_n) begin
							err_v = 1'b1;
							err_c = (phase_n == PH_MARKER) ? ERR_NO_MARKER : ERR_TRUNC;
						end
						rearm = arch.last_byte;
					end
				end else if (acc) begin
					rearm = arch.last_byte;
				end
			end
			C_POP_RD: begin
				ctl_n = C_POP_WR;
			end
			C_POP_WR: begin
				ram_we = 1'b1;
				ram_waddr = lvl_d[ADDR_W-1:0];
				ram_wdata = dec;
				if (dec == 32'd0 && lvl_d != '0) begin
					lvl_n = lvl_d;
					ctl_n = C_POP_RD;
				end else begin
					if (dec == 32'd0) begin
						lvl_n = lvl_d;
					end
					ctl_n = C_IDLE;
					cnt_n = '0;
					phase_n = (dec == 32'd0) ? PH_MARKER : PH_NLEN;
					have = 1'b1;
					r = hold_q;
					if (last_q) begin
						err_v = 1'b1;
						err_c = (dec == 32'd0) ? ERR_NO_MARKER : ERR_TRUNC;
					end
					rearm = last_q;
				end
			end
			default: begin
				ctl_n = C_IDLE;
			end
		endcase

		if (err_v) begin
			r = '0;
			r.record_kind = REC_ERROR;
			r.error_code = err_c;
			have = 1'b1;
			fin_n = 1'b1;
		end

		if (rearm) begin
			phase_n = PH_MAGIC;
			cnt_n = '0;
			shift_n = '0;
			nlen_n = '0;
			kind_n = '0;
			off_n = '0;
			len_n = '0;
			lvl_n = '0;
			fin_n = 1'b0;
		end

		load = have;
		out_n = have ? r : out_q;
		out_valid_n = have ? 1'b1 : (out_valid_q && !rec.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			ctl_q <= C_IDLE;
			cnt_q <= '0;
			shift_q <= '0;
			nlen_q <= '0;
			kind_q <= '0;
			off_q <= '0;
			len_q <= '0;
			lvl_q <= '0;
			fin_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			ctl_q <= ctl_n;
			cnt_q <= cnt_n;
			shift_q <= shift_n;
			nlen_q <= nlen_n;
			kind_q <= kind_n;
			off_q <= off_n;
			len_q <= len_n;
			lvl_q <= lvl_n;
			fin_q <= fin_n;
			last_q <= last_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_n;
		if (load) begin
			out_q <= out_n;
		end
	end

	assign rec.valid = out_valid_q;
	assign rec.record_kind = out_q.record_kind;
	assign rec.depth = out_q.depth;
	assign rec.name_char = out_q.name_char;
	assign rec.name_length = out_q.name_length;
	assign rec.child_count = out_q.child_count;
	assign rec.data_offset = out_q.data_offset;
	assign rec.data_length = out_q.data_length;
	assign rec.file_checksum = out_q.file_checksum;
	assign rec.format_version = out_q.format_version;
	assign rec.header_size = out_q.header_size;
	assign rec.payload_size = out_q.payload_size;
	assign rec.error_code = out_q.error_code;

	// A pop walk only runs while some directory is open.
	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q != C_IDLE) |-> (lvl_q != '0))
		else $error("pop walk with empty stack");

	// A write-back always follows its own read cycle.
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q == C_POP_WR) |-> ($past(ctl_q) == C_POP_RD))
		else $error("write-back without read");

	// No byte is taken during a pop walk.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q != C_IDLE) |-> !arch.ready)
		else $error("byte accepted while popping");

	// The stack never grows past its bound.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_W'(MAX_DEPTH))
		else $error("stack level out of range");
endmodule
`default_nettype wire

@@ sv/aitp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module aitp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ sim/tb_archive_index_tree_parser.sv @@
// Testbench for archive_index_tree_parser: builds archives byte by byte, predicts
// every record and checks each one. Depends on aitp_pkg and the aitp_if interfaces.
`default_nettype none
module tb_archive_index_tree_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import aitp_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         hold;
	} arc_byte_t;

	localparam int QUIET_LIMIT = 4000;
	localparam logic [7:0] PAK_SIG[3] = '{8'h50, 8'h41, 8'h4B};
	localparam logic [7:0] DATA_SIG[4] = '{8'h44, 8'h41, 8'h54, 8'h41};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	aitp_byte_if arch();
	aitp_rec_if rec();

	archive_index_tree_parser DUT (.clk(clk), .arst_n(arst_n), .arch(arch), .rec(rec));

	always #4 clk = ~clk;

	arc_byte_t byte_queue[$];
	logic [7:0] arc[$];
	res_t expected_records[$];
	int cycle_no = 0;
	int quiet = 0;
	int errors = 0;
	bit taken = 1'b0;
	bit finished = 1'b0;

	// Parser state mirrored for prediction.
	phase_t ph;
	int unsigned fcnt;
	logic [63:0] shreg;
	logic [15:0] nlen;
	logic [7:0] kind_b;
	logic [63:0] off_s;
	logic [31:0] len_s;
	logic [4:0] lvl;
	logic [31:0] kids[MAX_DEPTH];
	bit done_f;

	function automatic void rearm();
		ph = PH_MAGIC; fcnt = 0; shreg = '0; nlen = '0; kind_b = '0;
		off_s = '0; len_s = '0; lvl = '0; done_f = 1'b0;
	endfunction

	function automatic bit gather(input logic [7:0] b, input int unsigned n);
		if (fcnt == 0)
			shreg = '0;
		shreg = shreg | (64'(b) << (8 * (fcnt & 7)));
		fcnt++;
		if (fcnt >= n) begin
			fcnt = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void open_name();
		fcnt = 0;
		ph = (nlen == 0) ? PH_KIND : PH_NAME;
	endfunction

	// A leaf is complete: close every directory whose children are all seen.
	function automatic void close_levels();
		while (lvl > 0) begin
			kids[lvl - 1] = kids[lvl - 1] - 1;
			if (kids[lvl - 1] != 0)
				break;
			lvl--;
		end
		fcnt = 0;
		ph = (lvl == 0) ? PH_MARKER : PH_NLEN;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic last);
		res_t r;
		bit have;
		int err;
		r = '0;
		have = 1'b0;
		err = -1;
		if (!done_f) begin
			case (ph)
				PH_MAGIC: begin
					if (b != PAK_SIG[fcnt % 3])
						err = ERR_MAGIC;
					else if (++fcnt >= 3) begin
						fcnt = 0;
						ph = PH_VERSION;
					end
				end
				PH_VERSION: begin
					kind_b = b;
					fcnt = 0;
					ph = PH_HSIZE;
				end
				PH_HSIZE: if (gather(b, 4)) begin
					len_s = shreg[31:0];
					ph = PH_DSIZE;
				end
				PH_DSIZE: if (gather(b, 4)) begin
					have = 1'b1;
					r.record_kind = REC_HEADER;
					r.format_version = kind_b;
					r.header_size = len_s;
					r.payload_size = shreg[31:0];
					ph = (kind_b == 8'd1) ? PH_STAMP : PH_NLEN;
				end
				PH_STAMP: if (++fcnt >= 64) begin
					fcnt = 0;
					ph = PH_NLEN;
				end
				PH_NLEN: begin
					if (b == 8'hFF) begin
						fcnt = 0;
						ph = PH_NLEN_LO;
					end else begin
						nlen = 16'(b);
						open_name();
					end
				end
				PH_NLEN_LO: begin
					nlen = 16'(b);
					ph = PH_NLEN_HI;
				end
				PH_NLEN_HI: begin
					nlen = {b, nlen[7:0]};
					open_name();
				end
				PH_NAME: begin
					have = 1'b1;
					r.record_kind = REC_NAME;
					r.depth = lvl;
					r.name_char = b;
					r.name_length = nlen;
					if (++fcnt >= nlen) begin
						fcnt = 0;
						ph = PH_KIND;
					end
				end
				PH_KIND: begin
					kind_b = b;
					fcnt = 0;
					ph = (b == 8'd1) ? PH_COUNT : PH_OFFSET;
				end
				PH_COUNT: if (gather(b, 4)) begin
					if (shreg[31:0] != 0 && lvl >= MAX_DEPTH)
						err = ERR_DEEP;
					else begin
						have = 1'b1;
						r.record_kind = REC_DIR;
						r.depth = lvl;
						r.name_length = nlen;
						r.child_count = shreg[31:0];
						if (shreg[31:0] == 0)
							close_levels();
						else begin
							kids[lvl] = shreg[31:0];
							lvl++;
							fcnt = 0;
							ph = PH_NLEN;
						end
					end
				end
				PH_OFFSET: if (gather(b, kind_b[1] ? 8 : 4)) begin
					off_s = shreg;
					ph = PH_FLEN;
				end
				PH_FLEN: if (gather(b, 4)) begin
					len_s = shreg[31:0];
					ph = PH_CSUM;
				end
				PH_CSUM: if (gather(b, 4)) begin
					have = 1'b1;
					r.record_kind = REC_FILE;
					r.depth = lvl;
					r.name_length = nlen;
					r.data_offset = off_s;
					r.data_length = len_s;
					r.file_checksum = shreg[31:0];
					close_levels();
				end
				PH_MARKER: begin
					if (b != DATA_SIG[fcnt & 3])
						err = ERR_NO_MARKER;
					else if (++fcnt >= 4) begin
						fcnt = 0;
						have = 1'b1;
						r.record_kind = REC_MARKER;
						done_f = 1'b1;
					end
				end
				default: done_f = 1'b1;
			endcase
			if (err < 0 && last && !done_f)
				err = (ph == PH_MARKER) ? ERR_NO_MARKER : ERR_TRUNC;
			if (err >= 0) begin
				r = '0;
				r.record_kind = REC_ERROR;
				r.error_code = 2'(err);
				have = 1'b1;
				done_f = 1'b1;
			end
		end
		if (last)
			rearm();
		if (have)
			expected_records.insert(expected_records.size(), r);
	endfunction

	// Archive construction helpers.
	function automatic void add_byte(input logic [7:0] v);
		arc.insert(arc.size(), v);
	endfunction

	task automatic put_word(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++)
			add_byte(v[8 * i +: 8]);
	endtask

	task automatic put_name(input int len, input bit long_form);
		if (long_form || len >= 255) begin
			add_byte(8'hFF);
			put_word(64'(len), 2);
		end else
			add_byte(8'(len));
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom));
	endtask

	task automatic put_header(input logic [7:0] ver);
		foreach (PAK_SIG[i])
			add_byte(PAK_SIG[i]);
		add_byte(ver);
		put_word({$urandom, $urandom}, 4);
		put_word({$urandom, $urandom}, 4);
		if (ver == 8'd1)
			for (int i = 0; i < 64; i++)
				add_byte(8'($urandom));
	endtask

	task automatic put_file(input logic [7:0] k, input logic [63:0] offs);
		add_byte(k);
		put_word(offs, k[1] ? 8 : 4);
		put_word({$urandom, $urandom}, 4);
		put_word({$urandom, $urandom}, 4);
	endtask

	task automatic put_dir(input logic [31:0] n);
		add_byte(KIND_DIR);
		put_word(64'(n), 4);
	endtask

	task automatic put_entry(input int depth_now);
		int n;
		logic [7:0] k;
		put_name($urandom_range(0, 4), $urandom_range(0, 7) == 0);
		if (depth_now < 3 && $urandom_range(0, 2) == 0) begin
			n = $urandom_range(0, 3);
			put_dir(n);
			for (int i = 0; i < n; i++)
				put_entry(depth_now + 1);
		end else begin
			k = 8'($urandom);
			if (k == KIND_DIR)
				k = 8'd0;
			put_file(k, {$urandom, $urandom});
		end
	endtask

	task automatic put_marker();
		foreach (DATA_SIG[i])
			add_byte(DATA_SIG[i]);
	endtask

	// Nested single-child directories ending in one file.
	task automatic put_chain(input int levels);
		for (int i = 0; i < levels; i++) begin
			put_name(1, 1'b0);
			put_dir(1);
		end
		put_name(0, 1'b0);
		put_file(8'd2, '1);
		put_marker();
	endtask

	// Moves the built archive to the send queue; the final word carries last.
	task automatic ship(input bit hold);
		arc_byte_t w;
		foreach (arc[i]) begin
			w.b = arc[i];
			w.last = (i == arc.size() - 1);
			w.hold = hold && (i == 0);
			byte_queue.insert(byte_queue.size(), w);
		end
		arc.delete();
	endtask

	// Predictor on accepted words; the sender below presents words at the falling edge.
	always @(posedge clk) begin
		taken <= arch.valid && arch.ready;
		if (arch.valid && arch.ready)
			predict_byte(arch.data_byte, arch.last_byte);
	end

	always @(negedge clk) begin
		bit calm;
		calm = cycle_no > 300 && cycle_no < 500;
		if (arst_n && (!arch.valid || taken)) begin
			if (byte_queue.size() > 0 &&
				!(byte_queue[0].hold && expected_records.size() > 0) &&
				(calm || $urandom_range(0, 99) >= 26)) begin
				arch.valid <= 1'b1;
				arch.data_byte <= byte_queue[0].b;
				arch.last_byte <= byte_queue[0].last;
				void'(byte_queue.pop_front());
			end else
				arch.valid <= 1'b0;
		end
		rec.ready <= arst_n && (calm || $urandom_range(0, 99) >= 26);
	end

	// Record checker and watchdog.
	always @(posedge clk) begin
		res_t e;
		cycle_no <= cycle_no + 1;
		if ((arch.valid && arch.ready) || (rec.valid && rec.ready))
			quiet <= 0;
		else if (arst_n)
			quiet <= quiet + 1;
		if (rec.valid && rec.ready) begin
			if (expected_records.size() == 0) begin
				$error("record with none expected: kind %0d", rec.record_kind);
				errors++;
			end else begin
				e = expected_records.pop_front();
				if (rec.record_kind !== e.record_kind) begin
					$error("record_kind exp %0d got %0d", e.record_kind, rec.record_kind); errors++; end
				if (rec.depth !== e.depth) begin
					$error("depth exp %0d got %0d", e.depth, rec.depth); errors++; end
				if (rec.name_char !== e.name_char) begin
					$error("name_char exp %h got %h", e.name_char, rec.name_char); errors++; end
				if (rec.name_length !== e.name_length) begin
					$error("name_length exp %0d got %0d", e.name_length, rec.name_length);
					errors++;
				end
				if (rec.child_count !== e.child_count) begin
					$error("child_count exp %h got %h", e.child_count, rec.child_count);
					errors++;
				end
				if (rec.data_offset !== e.data_offset) begin
					$error("data_offset exp %h got %h", e.data_offset, rec.data_offset);
					errors++;
				end
				if (rec.data_length !== e.data_length) begin
					$error("data_length exp %h got %h", e.data_length, rec.data_length);
					errors++;
				end
				if (rec.file_checksum !== e.file_checksum) begin
					$error("file_checksum exp %h got %h", e.file_checksum, rec.file_checksum);
					errors++;
				end
				if (rec.format_version !== e.format_version) begin
					$error("format_version exp %h got %h", e.format_version,
						rec.format_version);
					errors++;
				end
				if (rec.header_size !== e.header_size) begin
					$error("header_size exp %h got %h", e.header_size, rec.header_size);
					errors++;
				end
				if (rec.payload_size !== e.payload_size) begin
					$error("payload_size exp %h got %h", e.payload_size, rec.payload_size);
					errors++;
				end
				if (rec.error_code !== e.error_code) begin
					$error("error_code exp %0d got %0d", e.error_code, rec.error_code);
					errors++;
				end
			end
		end
		if (!finished && quiet >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int total;
		int mode;
		int cut;
		logic [7:0] ver;
		arch.valid = 1'b0;
		arch.data_byte = '0;
		arch.last_byte = 1'b0;
		rec.ready = 1'b0;
		rearm();
		foreach (kids[i])
			kids[i] = '0;

		// Directed archives.
		add_byte(8'h00);
		add_byte(8'h41);
		ship(1'b0);
		add_byte(PAK_SIG[0]);
		ship(1'b0);
		put_header(8'd0);
		put_name(0, 1'b0);
		put_file(8'd2, '1);
		put_marker();
		ship(1'b0);
		put_header(8'd0);
		put_name(3, 1'b1);
		put_file(8'hFE, '0);
		put_marker();
		add_byte(8'hFF);
		add_byte(8'h00);
		ship(1'b1);
		put_header(8'd1);
		put_name(2, 1'b1);
		put_dir(2);
		put_name(1, 1'b0);
		put_dir(0);
		put_name(2, 1'b0);
		put_file(8'h00, '1);
		put_marker();
		ship(1'b0);
		// A long name whose length needs the high byte, cut short inside the name.
		put_header(8'd0);
		add_byte(8'hFF);
		put_word(64'd300, 2);
		for (int i = 0; i < 5; i++)
			add_byte(8'($urandom));
		ship(1'b0);
		put_header(8'hFF);
		put_chain(16);
		ship(1'b1);
		put_header(8'd0);
		put_chain(17);
		ship(1'b0);
		put_header(8'd0);
		put_name(1, 1'b0);
		put_dir('1);
		ship(1'b0);
		put_header(8'd0);
		put_name(0, 1'b0);
		put_file(8'd0, 64'd5);
		add_byte(8'h44);
		add_byte(8'h58);
		ship(1'b0);
		put_header(8'd0);
		put_name(0, 1'b0);
		put_file(8'd0, 64'd5);
		add_byte(8'h44);
		ship(1'b0);

		// Random archives: mostly well formed, some cut short or damaged.
		total = byte_queue.size();
		while (total < 650) begin
			ver = ($urandom_range(0, 4) == 0) ? 8'd1 : 8'($urandom_range(0, 3) * 2);
			put_header(ver);
			put_entry(0);
			put_marker();
			if ($urandom_range(0, 3) == 0)
				for (int i = $urandom_range(1, 4); i > 0; i--)
					add_byte(8'($urandom));
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				cut = $urandom_range(1, arc.size() - 1);
				while (arc.size() > cut)
					void'(arc.pop_back());
			end else if (mode == 1)
				arc[$urandom_range(0, arc.size() - 1)] = 8'($urandom);
			total += arc.size();
			ship($urandom_range(0, 3) == 0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (byte_queue.size() == 0);
		@(posedge clk);
		while (arch.valid || expected_records.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		finished = 1'b1;
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
